@@ src/mmsu_pkg.sv @@
// ----------------------------------------------------------------------------
// mmsu_pkg
// Shared widths, register indexes and pipeline types for the min-max scaler.
// ----------------------------------------------------------------------------
package mmsu_pkg;

    localparam int DATA_W  = 32;
    localparam int INDEX_W = 2;

    // configuration register indexes
    typedef enum logic [INDEX_W-1:0] {
        REG_SIGNED_MODE = 2'd0,
        REG_LOW_BOUND   = 2'd1,
        REG_HIGH_BOUND  = 2'd2,
        REG_UNUSED      = 2'd3
    } cfg_reg_t;

    localparam logic [DATA_W-1:0] MID_CODE = {1'b1, {(DATA_W-1){1'b0}}};

    // per-item flags that ride alongside the division
    typedef struct packed {
        logic clamped;
        logic last;
    } side_t;

    // one request inside the divider: partial remainder, numerator bits
    // still to consume (top) merged with quotient bits produced (bottom)
    typedef struct packed {
        logic [DATA_W-1:0] rem;
        logic [DATA_W-1:0] bits;
        side_t             side;
    } div_item_t;

endpackage

@@ src/mmsu_div_pipe.sv @@
// ----------------------------------------------------------------------------
// mmsu_div_pipe
// Restoring divider, one quotient bit per register stage, with per-stage
// valid bits and a ready chain so bubbles close up under back-pressure.
// ----------------------------------------------------------------------------
module mmsu_div_pipe (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic [mmsu_pkg::DATA_W-1:0] divisor,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  mmsu_pkg::div_item_t       in_item,
    output logic                      out_valid,
    input  logic                      out_ready,
    output mmsu_pkg::div_item_t       out_item
);
    import mmsu_pkg::*;

    localparam int STAGES = DATA_W;

    logic      vld_reg  [STAGES];
    div_item_t item_reg [STAGES];
    div_item_t item_next[STAGES];
    logic      src_vld  [STAGES];
    logic      rdy      [STAGES+1];

    // ready chain: a stage may load when empty or when it drains onward
    always_comb begin
        rdy[STAGES] = out_ready;
        for (int i = STAGES - 1; i >= 0; i--) begin
            rdy[i] = !vld_reg[i] || rdy[i+1];
        end
    end

    // one restoring step per stage: shift in a numerator bit, subtract if it fits
    always_comb begin
        div_item_t       src;
        logic [DATA_W:0] trial;
        logic [DATA_W:0] diff;
        logic            fits;
        for (int i = 0; i < STAGES; i++) begin
            src        = (i == 0) ? in_item : item_reg[(i == 0) ? 0 : i-1];
            src_vld[i] = (i == 0) ? in_valid : vld_reg[(i == 0) ? 0 : i-1];
            trial      = {src.rem, src.bits[DATA_W-1]};
            diff       = trial - {1'b0, divisor};
            fits       = (trial >= {1'b0, divisor});
            item_next[i].rem  = fits ? diff[DATA_W-1:0] : trial[DATA_W-1:0];
            item_next[i].bits = {src.bits[DATA_W-2:0], fits};
            item_next[i].side = src.side;
        end
    end

    // advance the stages
    always_ff @(posedge aclk) begin
        for (int i = 0; i < STAGES; i++) begin
            if (!aresetn) begin
                vld_reg[i] <= 1'b0;
            end else if (rdy[i]) begin
                vld_reg[i] <= src_vld[i];
            end
            if (rdy[i] && src_vld[i]) begin
                item_reg[i] <= item_next[i];
            end
        end
    end

    assign in_ready  = rdy[0];
    assign out_valid = vld_reg[STAGES-1];
    assign out_item  = item_reg[STAGES-1];

endmodule

@@ src/minmax_scale_to_u32_inverted_unit.sv @@
// ----------------------------------------------------------------------------
// minmax_scale_to_u32_inverted_unit
// Pipeline: 37 register stages, the first loaded on the accepting edge.
// Throughput: one request per cycle while the result side is not stalled,
// set by the 32-stage bit-per-stage divider.
// Reset: synchronous active-low aresetn clears all valid bits and the
// configuration registers (signed_mode, low_bound, high_bound all zero).
// ----------------------------------------------------------------------------
module minmax_scale_to_u32_inverted_unit (
    input  logic                         aclk,
    input  logic                         aresetn,
    // configuration write channel
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [mmsu_pkg::INDEX_W-1:0] cfg_index,
    input  logic [mmsu_pkg::DATA_W-1:0]  cfg_data,
    // input stream
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [mmsu_pkg::DATA_W-1:0]  s_tdata,   // [31:0] sample
    input  logic                         s_tlast,   // is_last
    // result stream
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [mmsu_pkg::DATA_W-1:0]  m_tdata,   // [31:0] plotted
    output logic                         m_tuser,   // [0] clamped
    output logic                         m_tlast    // last_out
);
    import mmsu_pkg::*;

    // configuration registers and derived values
    logic              signed_mode_reg;
    logic [DATA_W-1:0] low_bound_reg;
    logic [DATA_W-1:0] high_bound_reg;
    logic [DATA_W-1:0] span_reg;
    logic              bad_reg;

    logic [DATA_W:0]   lo_key;
    logic [DATA_W:0]   hi_key;
    logic [DATA_W:0]   v_key;

    // front pipeline stages
    logic              p0_vld_reg, p1_vld_reg, p2_vld_reg, p3_vld_reg;
    logic              p0_rdy, p1_rdy, p2_rdy, p3_rdy;
    logic [DATA_W-1:0] p0_sample_reg, p1_sample_reg;
    logic              p0_last_reg, p1_last_reg;
    logic              p1_lt_reg, p1_gt_reg;
    logic [DATA_W-1:0] p2_offset_reg;
    side_t             p2_side_reg;
    logic [DATA_W-1:0] p2_offset_next;
    side_t             p2_side_next;
    logic [2*DATA_W-1:0] p3_num_reg;
    logic [2*DATA_W-1:0] p3_num_next;
    side_t             p3_side_reg;

    div_item_t         div_in;
    div_item_t         div_out;
    logic              div_in_rdy;
    logic              div_out_vld;
    logic              out_rdy;

    // accept every configuration request
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            signed_mode_reg <= 1'b0;
            low_bound_reg   <= '0;
            high_bound_reg  <= '0;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_reg_t'(cfg_index))
                REG_SIGNED_MODE: signed_mode_reg <= cfg_data[0];
                REG_LOW_BOUND:   low_bound_reg   <= cfg_data;
                REG_HIGH_BOUND:  high_bound_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    // ordered keys: extend by sign in signed mode, by zero otherwise
    assign lo_key = {signed_mode_reg & low_bound_reg[DATA_W-1], low_bound_reg};
    assign hi_key = {signed_mode_reg & high_bound_reg[DATA_W-1], high_bound_reg};
    assign v_key  = {signed_mode_reg & p0_sample_reg[DATA_W-1], p0_sample_reg};

    // hold span and the empty-range flag in registers; bounds are static in use
    always_ff @(posedge aclk) begin
        span_reg <= high_bound_reg - low_bound_reg;
        bad_reg  <= ($signed(hi_key) <= $signed(lo_key));
    end

    // ready chain through the front stages
    assign out_rdy = !m_tvalid || m_tready;
    assign p3_rdy  = !p3_vld_reg || div_in_rdy;
    assign p2_rdy  = !p2_vld_reg || p3_rdy;
    assign p1_rdy  = !p1_vld_reg || p2_rdy;
    assign p0_rdy  = !p0_vld_reg || p1_rdy;
    assign s_tready = p0_rdy;

    // stage 0: capture the request
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p0_vld_reg <= 1'b0;
        end else if (p0_rdy) begin
            p0_vld_reg <= s_tvalid;
        end
        if (p0_rdy && s_tvalid) begin
            p0_sample_reg <= s_tdata;
            p0_last_reg   <= s_tlast;
        end
    end

    // stage 1: compare the sample against both bounds
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_vld_reg <= 1'b0;
        end else if (p1_rdy) begin
            p1_vld_reg <= p0_vld_reg;
        end
        if (p1_rdy && p0_vld_reg) begin
            p1_sample_reg <= p0_sample_reg;
            p1_last_reg   <= p0_last_reg;
            p1_lt_reg     <= ($signed(v_key) < $signed(lo_key));
            p1_gt_reg     <= ($signed(v_key) > $signed(hi_key));
        end
    end

    // stage 2: clamp and take the offset from the low bound
    always_comb begin
        logic [DATA_W-1:0] vc;
        vc = p1_lt_reg ? low_bound_reg : (p1_gt_reg ? high_bound_reg : p1_sample_reg);
        p2_offset_next       = vc - low_bound_reg;
        p2_side_next.clamped = (p1_lt_reg || p1_gt_reg) && !bad_reg;
        p2_side_next.last    = p1_last_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p2_vld_reg <= 1'b0;
        end else if (p2_rdy) begin
            p2_vld_reg <= p1_vld_reg;
        end
        if (p2_rdy && p1_vld_reg) begin
            p2_offset_reg <= p2_offset_next;
            p2_side_reg   <= p2_side_next;
        end
    end

    // stage 3: numerator offset * (2^32 - 1) as a shift and subtract
    assign p3_num_next = {p2_offset_reg, {DATA_W{1'b0}}}
                       - {{DATA_W{1'b0}}, p2_offset_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p3_vld_reg <= 1'b0;
        end else if (p3_rdy) begin
            p3_vld_reg <= p2_vld_reg;
        end
        if (p3_rdy && p2_vld_reg) begin
            p3_num_reg  <= p3_num_next;
            p3_side_reg <= p2_side_reg;
        end
    end

    // divider: upper numerator half is below the span, so the quotient fits
    assign div_in.rem  = p3_num_reg[2*DATA_W-1:DATA_W];
    assign div_in.bits = p3_num_reg[DATA_W-1:0];
    assign div_in.side = p3_side_reg;

    mmsu_div_pipe u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .divisor   (span_reg),
        .in_valid  (p3_vld_reg),
        .in_ready  (div_in_rdy),
        .in_item   (div_in),
        .out_valid (div_out_vld),
        .out_ready (out_rdy),
        .out_item  (div_out)
    );

    // output register: invert the quotient, or drop to mid code on an empty range
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid <= 1'b0;
        end else if (out_rdy) begin
            m_tvalid <= div_out_vld;
        end
        if (out_rdy && div_out_vld) begin
            m_tdata <= bad_reg ? MID_CODE : ~div_out.bits;
            m_tuser <= div_out.side.clamped;
            m_tlast <= div_out.side.last;
        end
    end

endmodule

@@ dv/minmax_scale_checker.sv @@
// ----------------------------------------------------------------------------
// minmax_scale_checker
// Watches the configuration, sample and result channels of the min-max
// scaler. It keeps its own copy of the bounds and mode, works out the
// inverted scaled position for every accepted sample request, and compares
// each accepted result with the oldest outstanding prediction, field by field.
// ----------------------------------------------------------------------------
module minmax_scale_checker (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_valid,
    input  logic                          cfg_ready,
    input  logic [mmsu_pkg::INDEX_W-1:0]  cfg_index,
    input  logic [mmsu_pkg::DATA_W-1:0]   cfg_data,
    input  logic                          s_tvalid,
    input  logic                          s_tready,
    input  logic [mmsu_pkg::DATA_W-1:0]   s_tdata,    // [31:0] sample
    input  logic                          s_tlast,    // is_last
    input  logic                          m_tvalid,
    input  logic                          m_tready,
    input  logic [mmsu_pkg::DATA_W-1:0]   m_tdata,    // [31:0] plotted
    input  logic                          m_tuser,    // [0] clamped
    input  logic                          m_tlast,    // last_out
    output int                            mismatches,
    output int                            outstanding,
    output int                            results_checked
);
    import mmsu_pkg::*;

    localparam logic [63:0] FULL_SCALE  = 64'h0000_0000_FFFF_FFFF;
    localparam int          PRINT_LIMIT = 20;

    typedef struct packed {
        logic [DATA_W-1:0] sample;
        logic [DATA_W-1:0] plotted;
        logic              clamped;
        logic              last;
    } plot_result_t;

    logic              signed_sel;
    logic [DATA_W-1:0] low_reg;
    logic [DATA_W-1:0] high_reg;
    plot_result_t      plot_q[$];
    plot_result_t      want;

    initial begin
        mismatches      = 0;
        outstanding     = 0;
        results_checked = 0;
        signed_sel      = 1'b0;
        low_reg         = '0;
        high_reg        = '0;
    end

    // order 32 raw bits as a plain number under the given mode
    function automatic longint ordered_key(input logic [DATA_W-1:0] raw, input logic is_signed);
        if (is_signed)
            return longint'($signed(raw));
        return longint'({32'd0, raw});
    endfunction

    // clamp into the bounds, scale onto the full 32-bit range, invert
    function automatic plot_result_t plot_position(input logic [DATA_W-1:0] sample,
                                                   input logic last);
        longint       v;
        longint       lo;
        longint       hi;
        logic [63:0]  span;
        logic [63:0]  offset;
        logic [63:0]  scaled;
        plot_result_t r;
        v         = ordered_key(sample, signed_sel);
        lo        = ordered_key(low_reg, signed_sel);
        hi        = ordered_key(high_reg, signed_sel);
        r.sample  = sample;
        r.last    = last;
        r.clamped = 1'b0;
        if (hi <= lo) begin
            // empty or reversed range collapses to the mid code
            r.plotted = MID_CODE;
        end else begin
            span = 64'(hi - lo);
            if (v < lo) begin
                v         = lo;
                r.clamped = 1'b1;
            end else if (v > hi) begin
                v         = hi;
                r.clamped = 1'b1;
            end
            offset    = 64'(v - lo);
            scaled    = (offset * FULL_SCALE) / span;
            r.plotted = ~scaled[DATA_W-1:0];
        end
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [DATA_W-1:0] got,
                                   input logic [DATA_W-1:0] exp_val,
                                   input logic [DATA_W-1:0] sample);
        if (mismatches < PRINT_LIMIT)
            $display("MISMATCH %s at result %0d: got %h, want %h (sample %h)",
                     what, results_checked, got, exp_val, sample);
        mismatches++;
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            signed_sel = 1'b0;
            low_reg    = '0;
            high_reg   = '0;
            plot_q.delete();
        end else begin
            // track register writes
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_SIGNED_MODE: signed_sel = cfg_data[0];
                    REG_LOW_BOUND:   low_reg    = cfg_data;
                    REG_HIGH_BOUND:  high_reg   = cfg_data;
                    default: ;
                endcase
            end

            // predict every accepted sample request
            if (s_tvalid && s_tready)
                plot_q.push_back(plot_position(s_tdata, s_tlast));

            // compare every accepted result with the oldest prediction
            if (m_tvalid && m_tready) begin
                if (plot_q.size() == 0) begin
                    report_mismatch("unexpected result", m_tdata, '0, '0);
                end else begin
                    want = plot_q.pop_front();
                    if (m_tdata !== want.plotted)
                        report_mismatch("plotted", m_tdata, want.plotted, want.sample);
                    if (m_tuser !== want.clamped)
                        report_mismatch("clamped", 32'(m_tuser), 32'(want.clamped),
                                        want.sample);
                    if (m_tlast !== want.last)
                        report_mismatch("last_out", 32'(m_tlast), 32'(want.last),
                                        want.sample);
                end
                results_checked++;
            end
            outstanding = plot_q.size();
        end
    end

endmodule

@@ dv/tb_minmax_scale_to_u32_inverted_unit.sv @@
// ----------------------------------------------------------------------------
// tb_minmax_scale_to_u32_inverted_unit
// Drives the min-max scaler with a short directed set (bound extremes, both
// modes, clamping, equal and reversed bounds) and then with random columns
// under randomly chosen bounds. The sender works in bursts, the receiver
// stalls on its own pattern, and a checker compares every result.
// ----------------------------------------------------------------------------
module tb_minmax_scale_to_u32_inverted_unit;
    import mmsu_pkg::*;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int RANDOM_PHASES = 14;
    localparam int PHASE_ITEMS   = 125;
    localparam int DRAIN_CYCLES  = 45;

    // receiver stall patterns
    localparam int RDY_ALWAYS = 0;
    localparam int RDY_COIN   = 1;
    localparam int RDY_SPARSE = 2;

    logic                aclk;
    logic                aresetn;
    logic                cfg_valid;
    logic                cfg_ready;
    logic [INDEX_W-1:0]  cfg_index;
    logic [DATA_W-1:0]   cfg_data;
    logic                s_tvalid;
    logic                s_tready;
    logic [DATA_W-1:0]   s_tdata;   // [31:0] sample
    logic                s_tlast;   // is_last
    logic                m_tvalid;
    logic                m_tready;
    logic [DATA_W-1:0]   m_tdata;   // [31:0] plotted
    logic                m_tuser;   // [0] clamped
    logic                m_tlast;   // last_out

    int                  mismatches;
    int                  outstanding;
    int                  results_checked;

    int                  cycles;
    int                  burst_left;
    int                  items_sent;
    int                  settings_used;
    int                  rdy_left;
    int                  rdy_mode;
    logic [DATA_W-1:0]   cur_lo;
    logic [DATA_W-1:0]   cur_hi;
    logic [DATA_W-1:0]   column[$];
    logic [DATA_W-1:0]   a_raw;
    logic [DATA_W-1:0]   b_raw;
    logic [DATA_W-1:0]   swap_raw;

    minmax_scale_to_u32_inverted_unit DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    minmax_scale_checker u_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tlast         (s_tlast),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .m_tuser         (m_tuser),
        .m_tlast         (m_tlast),
        .mismatches      (mismatches),
        .outstanding     (outstanding),
        .results_checked (results_checked)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // give up on a hung run
    initial cycles = 0;
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding", cycles, outstanding);
            $display("DONE: errors detected");
            $finish;
        end
    end

    // stall the result side, switching at random between the patterns
    initial rdy_left = 0;
    always @(negedge aclk) begin
        if (rdy_left == 0) begin
            rdy_mode = $urandom_range(RDY_ALWAYS, RDY_SPARSE);
            rdy_left = $urandom_range(50, 300);
        end
        rdy_left--;
        case (rdy_mode)
            RDY_ALWAYS: m_tready <= 1'b1;
            RDY_COIN:   m_tready <= 1'($urandom_range(0, 1));
            default:    m_tready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    // offer one sample request; open a new burst after a random gap when due
    task automatic send_sample(input logic [DATA_W-1:0] value, input logic last);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap != 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            burst_left = $urandom_range(1, 24);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= value;
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
        burst_left--;
        items_sent++;
    endtask

    // hold the sender off until every prediction has been met
    task automatic drain();
        s_tvalid   <= 1'b0;
        burst_left = 0;
        while (outstanding != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    // leaves cfg_valid high; the caller lowers it after the last write
    task automatic write_reg(input cfg_reg_t idx, input logic [DATA_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
    endtask

    task automatic configure(input logic mode, input logic [DATA_W-1:0] lo,
                             input logic [DATA_W-1:0] hi);
        drain();
        // upper bits of the mode word carry noise
        write_reg(REG_SIGNED_MODE, ($urandom() & ~32'd1) | 32'(mode));
        write_reg(REG_LOW_BOUND, lo);
        write_reg(REG_HIGH_BOUND, hi);
        cfg_valid  <= 1'b0;
        cur_lo     = lo;
        cur_hi     = hi;
        settings_used++;
    endtask

    // send a column, marking its final sample
    task automatic play_column();
        foreach (column[i])
            send_sample(column[i], i == column.size() - 1);
    endtask

    // mostly in-range samples, some at and beyond the bounds, some noise
    function automatic logic [DATA_W-1:0] pick_sample();
        logic [DATA_W-1:0] span32;
        logic [63:0]       off;
        span32 = cur_hi - cur_lo;
        off    = {32'd0, $urandom()} % ({32'd0, span32} + 64'd1);
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: return cur_lo + off[DATA_W-1:0];
            6:       return cur_lo + 32'($urandom_range(0, 2)) - 32'd1;
            7:       return cur_hi + 32'($urandom_range(0, 2)) - 32'd1;
            8:       return cur_lo - 32'($urandom_range(1, 1000));
            default: return $urandom();
        endcase
    endfunction

    initial begin
        aresetn       = 1'b0;
        cfg_valid     = 1'b0;
        cfg_index     = REG_SIGNED_MODE;
        cfg_data      = '0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        s_tlast       = 1'b0;
        m_tready      = 1'b0;
        burst_left    = 0;
        items_sent    = 0;
        settings_used = 1;
        cur_lo        = '0;
        cur_hi        = '0;

        repeat (5) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // reset bounds are both zero: equal bounds
        column = '{32'h0000_0000, 32'hFFFF_FFFF};
        play_column();

        // the spare index must leave the registers alone
        drain();
        write_reg(REG_UNUSED, $urandom());
        cfg_valid <= 1'b0;

        // full unsigned range
        configure(1'b0, 32'h0000_0000, 32'hFFFF_FFFF);
        column = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0001, 32'h8000_0000,
                   32'hFFFF_FFFE};
        play_column();

        // narrow unsigned range: below, above, on both bounds, middle
        configure(1'b0, 32'd100, 32'd200);
        column = '{32'd99, 32'd201, 32'd100, 32'd200, 32'd150};
        play_column();

        // full signed range
        configure(1'b1, 32'h8000_0000, 32'h7FFF_FFFF);
        column = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF};
        play_column();

        // signed range around zero with clamping on either side
        configure(1'b1, 32'hFFFF_FFCE, 32'd50);
        column = '{32'hFFFF_FF9C, 32'd100, 32'd0};
        play_column();

        // reversed bounds, unsigned
        configure(1'b0, 32'd200, 32'd100);
        column = '{32'd150, 32'd50};
        play_column();

        // forward as unsigned but reversed as signed
        configure(1'b1, 32'd5, 32'hFFFF_FFFB);
        column = '{32'd0, 32'd7};
        play_column();

        // equal non-zero bounds, signed
        configure(1'b1, 32'hFFFF_FFF0, 32'hFFFF_FFF0);
        column = '{32'hFFFF_FFF0, 32'h0000_0000};
        play_column();

        // random columns under random bounds, alternating the mode
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            a_raw = $urandom();
            b_raw = $urandom();
            if ((ph & 1) ? ($signed(a_raw) > $signed(b_raw)) : (a_raw > b_raw)) begin
                swap_raw = a_raw;
                a_raw    = b_raw;
                b_raw    = swap_raw;
            end
            case ($urandom_range(0, 7))
                0: begin
                    a_raw = (ph & 1) ? 32'h8000_0000 : 32'h0000_0000;
                    b_raw = ~a_raw;
                end
                1, 2: ;
                3: b_raw = a_raw + 32'($urandom_range(1, 16));
                4: b_raw = a_raw + 32'd1;
                5: b_raw = a_raw;
                6: begin
                    swap_raw = a_raw;
                    a_raw    = b_raw;
                    b_raw    = swap_raw;
                end
                default: begin
                    a_raw = 32'($urandom_range(0, 255)) ^ ((ph & 1) ? 32'h8000_0000 : 32'h0);
                    b_raw = ~a_raw;
                end
            endcase
            configure(1'(ph & 1), a_raw, b_raw);
            for (int n = 0; n < PHASE_ITEMS; n++)
                send_sample(pick_sample(),
                            (n == PHASE_ITEMS - 1) || ($urandom_range(0, 7) == 0));
        end

        drain();
        repeat (DRAIN_CYCLES) @(negedge aclk);

        $display("covered %0d samples under %0d bound settings in both modes,", items_sent,
                 settings_used);
        $display("including clamping, equal and reversed bounds; %0d results compared",
                 results_checked);
        if (mismatches == 0 && outstanding == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
